>>> hdl/glw_pkg.sv
package glw_pkg;

	// fixed field widths of the item and result beats
	localparam int COORD_W = 6;
	localparam int STEPS_W = 7;

	// command codes
	typedef enum logic {
		CMD_TRACE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	// walker status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic mark_valid;
	} walk_stat_t;

endpackage

>>> hdl/glw_map.sv
module glw_map #(
	parameter int GRID_SIDE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         mark_valid,
	input  logic [$clog2(GRID_SIDE)-1:0] mark_x,
	input  logic [$clog2(GRID_SIDE)-1:0] mark_y,
	input  logic                         rd_en,
	input  logic [$clog2(GRID_SIDE)-1:0] rd_x,
	input  logic [$clog2(GRID_SIDE)-1:0] rd_y,
	output logic                         rd_data,
	output logic                         clear_busy
);
	import glw_pkg::*;

	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);

	logic          mem [DEPTH];
	logic [AW-1:0] clr_addr_q;
	logic          clr_busy_q;
	logic [AW-1:0] mark_addr;
	logic [AW-1:0] rd_addr;
	logic          rd_data_q;

	// cell index is row * side + column
	assign mark_addr = AW'(AW'(mark_x) * AW'(GRID_SIDE) + AW'(mark_y));
	assign rd_addr   = AW'(AW'(rd_x) * AW'(GRID_SIDE) + AW'(rd_y));

	// clearing sweep after reset, one cell a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= 1'b0;
		end else if (mark_valid) begin
			mem[mark_addr] <= 1'b1;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data    = rd_data_q;
	assign clear_busy = clr_busy_q;

	// no marking or reading while the sweep owns the memory
	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> (!mark_valid && !rd_en))
		else $error("map accessed during clearing sweep");

endmodule

>>> hdl/glw_walker.sv
module glw_walker #(
	parameter int GRID_SIDE = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic [$clog2(GRID_SIDE)-1:0]         sx,
	input  logic [$clog2(GRID_SIDE)-1:0]         sy,
	input  logic [$clog2(GRID_SIDE)-1:0]         gx,
	input  logic [$clog2(GRID_SIDE)-1:0]         gy,
	output glw_pkg::walk_stat_t                  stat,
	output logic [$clog2(GRID_SIDE)-1:0]         mark_x,
	output logic [$clog2(GRID_SIDE)-1:0]         mark_y,
	output logic [$clog2(2*GRID_SIDE-1)-1:0]     steps
);
	import glw_pkg::*;

	localparam int CW  = $clog2(GRID_SIDE);
	localparam int PW  = 2 * CW + 1;
	localparam int SCW = $clog2(2 * GRID_SIDE - 1);

	logic [CW-1:0]  x_q, y_q;
	logic           up_x_q, up_y_q;
	logic [CW-1:0]  rx_q, ry_q;
	logic [PW-1:0]  lhs_q, rhs_q;
	logic [PW-1:0]  lhs_inc_q, rhs_inc_q;
	logic [SCW-1:0] steps_q;
	logic           mark_valid_s1;
	logic [CW-1:0]  mark_x_s1, mark_y_s1;

	logic [CW-1:0]  dx, dy;
	logic           busy;
	logic           step_x, step_y;
	logic [CW-1:0]  x_nxt, y_nxt;

	// span of the line on each axis
	assign dx = (gx > sx) ? gx - sx : sx - gx;
	assign dy = (gy > sy) ? gy - sy : sy - gy;

	// (1+2*ix)*ny against (1+2*iy)*nx, kept as running sums
	assign busy   = (rx_q != '0) || (ry_q != '0);
	assign step_x = lhs_q <= rhs_q;
	assign step_y = lhs_q >= rhs_q;

	// next cell entered
	always_comb begin
		x_nxt = x_q;
		y_nxt = y_q;
		if (step_x) begin
			x_nxt = up_x_q ? x_q + CW'(1) : x_q - CW'(1);
		end
		if (step_y) begin
			y_nxt = up_y_q ? y_q + CW'(1) : y_q - CW'(1);
		end
	end

	// control: remaining steps, step count, mark request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_q          <= '0;
			ry_q          <= '0;
			steps_q       <= '0;
			mark_valid_s1 <= 1'b0;
		end else if (load) begin
			rx_q          <= dx;
			ry_q          <= dy;
			steps_q       <= '0;
			mark_valid_s1 <= 1'b0;
		end else begin
			mark_valid_s1 <= busy;
			if (busy) begin
				if (step_x) begin
					rx_q <= rx_q - CW'(1);
				end
				if (step_y) begin
					ry_q <= ry_q - CW'(1);
				end
				steps_q <= steps_q + SCW'(1);
			end
		end
	end

	// datapath: position and comparison sums
	always_ff @(posedge clk) begin
		if (load) begin
			x_q       <= sx;
			y_q       <= sy;
			up_x_q    <= gx > sx;
			up_y_q    <= gy > sy;
			lhs_q     <= PW'(dy);
			rhs_q     <= PW'(dx);
			lhs_inc_q <= PW'(dy) << 1;
			rhs_inc_q <= PW'(dx) << 1;
		end else if (busy) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			if (step_x) begin
				lhs_q <= lhs_q + lhs_inc_q;
			end
			if (step_y) begin
				rhs_q <= rhs_q + rhs_inc_q;
			end
			mark_x_s1 <= x_nxt;
			mark_y_s1 <= y_nxt;
		end
	end

	assign stat.busy       = busy;
	assign stat.mark_valid = mark_valid_s1;
	assign mark_x          = mark_x_s1;
	assign mark_y          = mark_y_s1;
	assign steps           = steps_q;

	// a walk never runs past its longest possible length
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (steps_q < SCW'(2 * (GRID_SIDE - 1))))
		else $error("walk exceeded step bound");

endmodule

>>> hdl/grid_line_walk_marker_unit.sv
// Grid line walk marker. Keeps a GRID_SIDE x GRID_SIDE bitmap of observed cells in one
// synchronous memory. A trace beat walks from the start cell to the goal cell in diagonal,
// row or column steps and marks each entered cell (not the start cell); its result carries
// the step count. A query beat returns the observed bit of the start cell. Coordinates above
// GRID_SIDE-1 saturate. One item is worked on at a time: a trace lasts as long as its walk
// (steps is at most 2*(GRID_SIDE-1)), the walker marking one cell per cycle through the
// memory write port; a query waits for the registered memory read. After reset the
// memory is swept clear one cell a cycle, all GRID_SIDE*GRID_SIDE cells (4096 at the
// default), while cmd_stall stays high. A finished result waits in the output register
// while the next command is taken.
module grid_line_walk_marker_unit #(
	parameter int GRID_SIDE = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic                         command,
	input  logic [glw_pkg::COORD_W-1:0]  start_x,
	input  logic [glw_pkg::COORD_W-1:0]  start_y,
	input  logic [glw_pkg::COORD_W-1:0]  goal_x,
	input  logic [glw_pkg::COORD_W-1:0]  goal_y,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         observed,
	output logic [glw_pkg::STEPS_W-1:0]  steps_taken
);
	import glw_pkg::*;

	localparam int          CW   = $clog2(GRID_SIDE);
	localparam int          SCW  = $clog2(2 * GRID_SIDE - 1);
	localparam int unsigned CMAX = GRID_SIDE - 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_READ,
		ST_READ_WAIT,
		ST_RESULT
	} state_t;

	state_t               state_q;
	logic                 res_valid_q;
	logic                 observed_q;
	logic [STEPS_W-1:0]   steps_taken_q;
	logic                 res_obs_q;
	logic [STEPS_W-1:0]   res_steps_q;
	logic [CW-1:0]        qx_q, qy_q;

	logic                 cmd_accept;
	logic                 is_query;
	logic [CW-1:0]        sx_c, sy_c, gx_c, gy_c;
	logic                 walk_load;
	logic                 rd_en;
	logic                 rd_data;
	logic                 clear_busy;
	logic                 out_free;
	walk_stat_t           wstat;
	logic [CW-1:0]        mark_x, mark_y;
	logic [SCW-1:0]       walk_steps;

	assign cmd_stall  = (state_q != ST_IDLE);
	assign cmd_accept = cmd_valid && !cmd_stall;
	assign is_query   = (cmd_t'(command) == CMD_QUERY);
	assign walk_load  = cmd_accept && !is_query;
	assign out_free   = !res_valid_q || !res_stall;

	// saturate coordinates to the grid
	assign sx_c = (32'(start_x) > CMAX) ? CW'(CMAX) : CW'(start_x);
	assign sy_c = (32'(start_y) > CMAX) ? CW'(CMAX) : CW'(start_y);
	assign gx_c = (32'(goal_x) > CMAX) ? CW'(CMAX) : CW'(goal_x);
	assign gy_c = (32'(goal_y) > CMAX) ? CW'(CMAX) : CW'(goal_y);

	// read only once the last mark write has landed
	assign rd_en = (state_q == ST_READ) && !wstat.mark_valid;

	glw_walker #(
		.GRID_SIDE(GRID_SIDE)
	) u_walker (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (walk_load),
		.sx     (sx_c),
		.sy     (sy_c),
		.gx     (gx_c),
		.gy     (gy_c),
		.stat   (wstat),
		.mark_x (mark_x),
		.mark_y (mark_y),
		.steps  (walk_steps)
	);

	glw_map #(
		.GRID_SIDE(GRID_SIDE)
	) u_map (
		.clk        (clk),
		.arst_n     (arst_n),
		.mark_valid (wstat.mark_valid),
		.mark_x     (mark_x),
		.mark_y     (mark_y),
		.rd_en      (rd_en),
		.rd_x       (qx_q),
		.rd_y       (qy_q),
		.rd_data    (rd_data),
		.clear_busy (clear_busy)
	);

	// query cell hold, no reset needed
	always_ff @(posedge clk) begin
		if (cmd_accept) begin
			qx_q <= sx_c;
			qy_q <= sy_c;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			res_valid_q   <= 1'b0;
			observed_q    <= 1'b0;
			steps_taken_q <= '0;
			res_obs_q     <= 1'b0;
			res_steps_q   <= '0;
		end else begin
			// taken beat leaves unless a new one replaces it
			if (res_valid_q && !res_stall && (state_q != ST_RESULT)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (!clear_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_accept) begin
						state_q <= is_query ? ST_READ : ST_WALK;
					end
				end
				ST_WALK: begin
					if (!wstat.busy) begin
						res_obs_q   <= 1'b0;
						res_steps_q <= STEPS_W'(walk_steps);
						state_q     <= ST_RESULT;
					end
				end
				ST_READ: begin
					if (rd_en) begin
						state_q <= ST_READ_WAIT;
					end
				end
				ST_READ_WAIT: begin
					res_obs_q   <= rd_data;
					res_steps_q <= '0;
					state_q     <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						res_valid_q   <= 1'b1;
						observed_q    <= res_obs_q;
						steps_taken_q <= res_steps_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid   = res_valid_q;
	assign observed    = observed_q;
	assign steps_taken = steps_taken_q;

	// interlock: no read while a mark write is still in flight
	a_read_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wstat.mark_valid)
		else $error("map read overlaps pending mark");

	// the walker only steps inside a trace
	a_walk_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		wstat.busy |-> (state_q == ST_WALK))
		else $error("walker busy outside trace");

	// a query result carries no step count
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && observed_q) |-> (steps_taken_q == '0))
		else $error("result mixes query and trace fields");

	// an accepted command leaves idle at once
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_accept |=> (state_q == ST_WALK || state_q == ST_READ))
		else $error("accepted command not started");

endmodule

>>> sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import glw_pkg::*;

	localparam int GRID_SIDE    = 64;
	localparam int CELLS        = GRID_SIDE * GRID_SIDE;
	localparam int MAX_STEPS    = 2 * (GRID_SIDE - 1);
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 4 * MAX_STEPS;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 1450;
	localparam int PRINT_CAP    = 50;

	typedef logic [COORD_W-1:0] coord_t;

	typedef struct {
		cmd_t                 cmd;
		coord_t               sx, sy, gx, gy;
		logic                 observed;
		logic [STEPS_W-1:0]   steps;
	} walk_outcome_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                cmd_valid   = 1'b0;
	logic                cmd_stall;
	logic                command     = 1'b0;
	coord_t              start_x     = '0;
	coord_t              start_y     = '0;
	coord_t              goal_x      = '0;
	coord_t              goal_y      = '0;
	logic                res_valid;
	logic                res_stall   = 1'b0;
	logic                observed;
	logic [STEPS_W-1:0]  steps_taken;

	// shadow of the observed bitmap and the results still owed by the block
	bit                  cell_map [CELLS];
	int                  lit_cells [$];
	walk_outcome_t       pending_results [$];

	int  cycle_count  = 0;
	int  fail_count   = 0;
	int  trace_count  = 0;
	int  query_count  = 0;
	int  query_hits   = 0;
	int  longest_walk = 0;
	int  send_quiet   = 0;
	int  hold_id      = 0;

	// receiver stall state
	int  stall_roll;
	int  hold_seen    = 0;
	int  hold_left    = 0;
	int  stall_left   = 0;
	int  quiet_left   = 0;

	grid_line_walk_marker_unit #(
		.GRID_SIDE(GRID_SIDE)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.command    (command),
		.start_x    (start_x),
		.start_y    (start_y),
		.goal_x     (goal_x),
		.goal_y     (goal_y),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.observed   (observed),
		.steps_taken(steps_taken)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	function automatic int clamp_coord(input int v);
		return (v > GRID_SIDE - 1) ? GRID_SIDE - 1 : v;
	endfunction

	// supercover walk, marks every entered cell except the start
	function automatic int walk_and_mark(input int sx, input int sy, input int gx,
		input int gy);
		int  nx, ny, x, y, ix, iy, n, lhs, rhs, idx;
		bit  up_x, up_y;
		nx = (gx > sx) ? gx - sx : sx - gx;
		ny = (gy > sy) ? gy - sy : sy - gy;
		up_x = gx > sx;
		up_y = gy > sy;
		x = sx;
		y = sy;
		ix = 0;
		iy = 0;
		n = 0;
		while ((ix < nx || iy < ny) && n < MAX_STEPS) begin
			lhs = (1 + 2 * ix) * ny;
			rhs = (1 + 2 * iy) * nx;
			if (lhs <= rhs) begin
				x = up_x ? x + 1 : x - 1;
				ix++;
			end
			if (lhs >= rhs) begin
				y = up_y ? y + 1 : y - 1;
				iy++;
			end
			idx = (x * GRID_SIDE + y) % CELLS;
			if (!cell_map[idx])
				lit_cells.push_back(idx);
			cell_map[idx] = 1'b1;
			n++;
		end
		return n;
	endfunction

	// expected result of one accepted command beat, updates the shadow map
	function automatic walk_outcome_t walk_outcome(input cmd_t c, input coord_t sx,
		input coord_t sy, input coord_t gx, input coord_t gy);
		walk_outcome_t r;
		int            n;
		r.cmd = c;
		r.sx = sx;
		r.sy = sy;
		r.gx = gx;
		r.gy = gy;
		r.observed = 1'b0;
		r.steps = '0;
		if (c == CMD_QUERY) begin
			r.observed = cell_map[clamp_coord(sx) * GRID_SIDE + clamp_coord(sy)];
		end else begin
			n = walk_and_mark(clamp_coord(sx), clamp_coord(sy), clamp_coord(gx),
				clamp_coord(gy));
			r.steps = n[STEPS_W-1:0];
			if (n > longest_walk)
				longest_walk = n;
		end
		return r;
	endfunction

	// sender idle gaps: mostly none or short, a few long, some stretches with no gaps
	function automatic int pick_gap();
		int r;
		if (send_quiet != 0) begin
			send_quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			send_quiet = $urandom_range(20, 80);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 15);
		return $urandom_range(30, 150);
	endfunction

	// drive one command beat and wait for it to be taken
	task automatic send_item(input cmd_t c, input coord_t sx, input coord_t sy,
		input coord_t gx, input coord_t gy, input bit back_to_back = 1'b0);
		int gap;
		gap = back_to_back ? 0 : pick_gap();
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= c;
		start_x   <= sx;
		start_y   <= sy;
		goal_x    <= gx;
		goal_y    <= gy;
		do
			@(posedge clk);
		while (cmd_stall !== 1'b0);
		pending_results.push_back(walk_outcome(c, sx, sy, gx, gy));
		if (c == CMD_QUERY) begin
			query_count++;
			if (pending_results[$].observed)
				query_hits++;
		end else begin
			trace_count++;
		end
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom_range(0, GRID_SIDE - 1));
	endfunction

	function automatic coord_t near_coord(input coord_t base);
		int v;
		v = int'(base) + $urandom_range(0, 16) - 8;
		if (v < 0)
			v = 0;
		if (v > GRID_SIDE - 1)
			v = GRID_SIDE - 1;
		return coord_t'(v);
	endfunction

	// one random beat: traces mostly short, some between random cells; queries biased to marked cells
	task automatic send_random(input bit back_to_back = 1'b0);
		int      r, idx;
		coord_t  sx, sy, gx, gy;
		r = $urandom_range(0, 99);
		sx = rand_coord();
		sy = rand_coord();
		gx = rand_coord();
		gy = rand_coord();
		if (r < 55) begin
			if ($urandom_range(0, 3) != 0) begin
				gx = near_coord(sx);
				gy = near_coord(sy);
			end
			send_item(CMD_TRACE, sx, sy, gx, gy, back_to_back);
		end else begin
			if (lit_cells.size() != 0 && $urandom_range(0, 9) < 6) begin
				idx = lit_cells[$urandom_range(0, lit_cells.size() - 1)];
				sx = coord_t'(idx / GRID_SIDE);
				sy = coord_t'(idx % GRID_SIDE);
			end
			send_item(CMD_QUERY, sx, sy, gx, gy, back_to_back);
		end
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// receiver stall pattern, with a long hold whenever hold_id moves
	always @(posedge clk) begin
		if (hold_id != hold_seen) begin
			hold_seen = hold_id;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
			if (quiet_left != 0) begin
				quiet_left--;
			end else begin
				stall_roll = $urandom_range(0, 99);
				if (stall_roll < 15)
					stall_left = $urandom_range(1, 3);
				else if (stall_roll < 18)
					stall_left = $urandom_range(8, 60);
				else if (stall_roll < 20)
					quiet_left = $urandom_range(50, 300);
			end
		end
	end

	// result beat check against the oldest expectation
	always @(posedge clk) begin
		walk_outcome_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing expected (obs %b steps %0d)",
					observed, steps_taken));
			end else begin
				want = pending_results.pop_front();
				if (observed !== want.observed)
					report_mismatch($sformatf("%s (%0d,%0d)->(%0d,%0d): observed %b, want %b",
						want.cmd.name(), want.sx, want.sy, want.gx, want.gy, observed,
						want.observed));
				if (steps_taken !== want.steps)
					report_mismatch($sformatf("%s (%0d,%0d)->(%0d,%0d): steps %0d, want %0d",
						want.cmd.name(), want.sx, want.sy, want.gx, want.gy, steps_taken,
						want.steps));
			end
		end
	end

	// map reads back clear after the reset sweep
	task automatic test_cleared_map();
		send_item(CMD_QUERY, 6'd0, 6'd0, 6'd63, 6'd63);
		send_item(CMD_QUERY, 6'd63, 6'd63, 6'd0, 6'd0);
		send_item(CMD_QUERY, 6'd0, 6'd63, rand_coord(), rand_coord());
	endtask

	// corner cases of the walk and of the start/goal marking
	task automatic test_directed_lines();
		send_item(CMD_TRACE, 6'd10, 6'd10, 6'd10, 6'd10);
		send_item(CMD_QUERY, 6'd10, 6'd10, 6'd0, 6'd0);
		send_item(CMD_TRACE, 6'd0, 6'd0, 6'd63, 6'd63);
		send_item(CMD_QUERY, 6'd0, 6'd0, 6'd63, 6'd63);
		send_item(CMD_QUERY, 6'd63, 6'd63, 6'd0, 6'd0);
		send_item(CMD_TRACE, 6'd63, 6'd0, 6'd0, 6'd63);
		send_item(CMD_QUERY, 6'd0, 6'd63, 6'd63, 6'd63);
		send_item(CMD_TRACE, 6'd0, 6'd1, 6'd63, 6'd63);
		send_item(CMD_TRACE, 6'd63, 6'd62, 6'd0, 6'd0);
		send_item(CMD_TRACE, 6'd5, 6'd0, 6'd5, 6'd63);
		send_item(CMD_QUERY, 6'd5, 6'd63, 6'd0, 6'd0);
		send_item(CMD_TRACE, 6'd63, 6'd40, 6'd0, 6'd40);
		send_item(CMD_QUERY, 6'd0, 6'd40, 6'd63, 6'd63);
		send_item(CMD_TRACE, 6'd20, 6'd30, 6'd23, 6'd31);
		send_item(CMD_TRACE, 6'd42, 6'd21, 6'd21, 6'd42);
		send_item(CMD_QUERY, 6'd21, 6'd42, 6'd63, 6'd63);
		send_item(CMD_QUERY, 6'd42, 6'd21, 6'd0, 6'd0);
		send_item(CMD_QUERY, 6'd33, 6'd7, 6'd63, 6'd63);
		wait_idle();
	endtask

	// long receiver hold while commands keep coming, so the block backs up
	task automatic test_receiver_hold();
		hold_id <= hold_id + 1;
		repeat (40)
			send_random(1'b1);
		wait_idle();
	endtask

	// bursts separated by full drains
	task automatic test_sender_pause();
		repeat (3) begin
			repeat (10)
				send_random();
			wait_idle();
		end
	endtask

	task automatic test_random_mix();
		repeat (RANDOM_ITEMS)
			send_random();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_map();
		test_directed_lines();
		test_receiver_hold();
		test_sender_pause();
		test_random_mix();

		// drain and report
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("walked %0d traces (longest %0d steps), %0d queries with %0d on marked cells",
			trace_count, longest_walk, query_count, query_hits);
		$display("one %0d-cycle result hold, %0d marked cells, %0d mismatches",
			HOLD_CYCLES, lit_cells.size(), fail_count);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
